[design/ita_pkg.sv]
package ita_pkg;

    // digit row geometry
    localparam int NUM_CELLS  = 16;
    localparam int DIG_W      = 4;
    localparam int REM_W      = $clog2(NUM_CELLS + 1);
    localparam int MAG_W      = 32;
    localparam int BIT_CNT_W  = $clog2(MAG_W);
    localparam int OCT_DIGITS = (MAG_W + 2) / 3;

    // mode codes
    localparam logic [2:0] MODE_SDEC  = 3'd0;
    localparam logic [2:0] MODE_UDEC  = 3'd1;
    localparam logic [2:0] MODE_OCT   = 3'd2;
    localparam logic [2:0] MODE_HEX   = 3'd3;
    localparam logic [2:0] MODE_HEX0X = 3'd4;

    // prefix sequencing codes
    localparam logic [1:0] PFX_NONE  = 2'd0;
    localparam logic [1:0] PFX_MINUS = 2'd1;
    localparam logic [1:0] PFX_ZERO  = 2'd2;
    localparam logic [1:0] PFX_X     = 2'd3;

    // characters
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // per-cycle command to every cell of the row
    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } ita_cell_ctrl_t;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
        logic [7:0] d8;
        d8 = {{(8 - DIG_W){1'b0}}, d};
        if (d < DIG_W'(10))
            return CHAR_0 + d8;
        else
            return CHAR_A + d8 - 8'd10;
    endfunction

endpackage

[design/ita_cell.sv]
module ita_cell
    import ita_pkg::*;
(
    input  logic             clk,
    input  ita_cell_ctrl_t   ctrl,
    input  logic [DIG_W-1:0] load_dig,
    input  logic             bit_in,
    input  logic [DIG_W-1:0] dig_in,
    output logic [DIG_W-1:0] dig,
    output logic             carry
);

    logic [DIG_W-1:0] dig_reg;
    logic [DIG_W-1:0] dig_next;
    logic [DIG_W-1:0] adj;

    // add-3 correction before the doubling step
    assign adj   = (dig_reg >= DIG_W'(5)) ? dig_reg + DIG_W'(3) : dig_reg;
    assign carry = adj[DIG_W-1];
    assign dig   = dig_reg;

    always_comb
    begin
        dig_next = dig_reg;
        if (ctrl.load)
            dig_next = load_dig;
        else if (ctrl.dabble)
            dig_next = {adj[DIG_W-2:0], bit_in};
        else if (ctrl.shift)
            dig_next = dig_in;
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

endmodule

[design/integer_to_ascii_radix.sv]
// Integer to ASCII text converter, decimal / octal / hex.
// Input channel (in_valid/in_ready) takes one word: mode and value. Output
// channel (out_valid/out_ready) gives one character per word, most
// significant first, with last set on the final character of the text.
// A row of 16 four-bit digit cells holds the number. Hex and octal words
// load the cells directly; decimal words run the 32 magnitude bits
// through the row by shift-and-add-3, one bit per cycle.
// The row then shifts up one digit per cycle past leading zeros, then
// one digit per character emitted, one character per cycle while the
// output register is free; prefix characters ('-' or "0x") come first.
// One word is in work at a time, and in_ready is high only between words.
// Mode codes 5 to 7 are taken and give no characters.
// The output register lets the last character wait while the next word
// is accepted. A stalled receiver holds the row until out_ready returns.
// Reset clears the sequencer and the output valid; no clearing pass.
module integer_to_ascii_radix
    import ita_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  character,
    output logic        last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [1:0]           pfx_reg, pfx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           character_reg, character_next;
    logic                 last_reg, last_next;

    ita_cell_ctrl_t       cell_ctrl;
    logic [DIG_W-1:0]     load_dig [NUM_CELLS];
    logic [DIG_W-1:0]     dig      [NUM_CELLS];
    logic                 carry    [NUM_CELLS];
    logic [MAG_W:0]       oct_pad;
    logic [MAG_W-1:0]     low_word;
    logic                 neg;
    logic                 is_hex;
    logic                 slot_free;
    logic [DIG_W-1:0]     top_dig;
    logic                 bcd_ok;

    assign low_word = value[MAG_W-1:0];
    assign oct_pad  = {1'b0, low_word};
    assign neg      = (mode == MODE_SDEC) && low_word[MAG_W-1];
    assign is_hex   = (mode == MODE_HEX) || (mode == MODE_HEX0X);
    assign top_dig  = dig[NUM_CELLS-1];

    // digit row
    for (genvar gi = 0; gi < NUM_CELLS; gi++)
    begin : g_cell
        logic [DIG_W-1:0] oct_dig;

        if (gi < OCT_DIGITS)
        begin : g_oct
            assign oct_dig = {1'b0, oct_pad[3*gi +: 3]};
        end
        else
        begin : g_no_oct
            assign oct_dig = '0;
        end

        assign load_dig[gi] = is_hex ? value[DIG_W*gi +: DIG_W] :
                              (mode == MODE_OCT) ? oct_dig : '0;

        if (gi == 0)
        begin : g_first
            ita_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .load_dig (load_dig[gi]),
                .bit_in   (mag_reg[MAG_W-1]),
                .dig_in   ('0),
                .dig      (dig[gi]),
                .carry    (carry[gi])
            );
        end
        else
        begin : g_rest
            ita_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .load_dig (load_dig[gi]),
                .bit_in   (carry[gi-1]),
                .dig_in   (dig[gi-1]),
                .dig      (dig[gi]),
                .carry    (carry[gi])
            );
        end
    end

    // every cell a legal BCD digit
    always_comb
    begin
        bcd_ok = 1'b1;
        for (int i = 0; i < NUM_CELLS; i++)
            if (dig[i] > DIG_W'(9))
                bcd_ok = 1'b0;
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        pfx_next       = pfx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        character_next = character_reg;
        last_next      = last_reg;
        cell_ctrl      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next     = REM_W'(NUM_CELLS);
                    bit_cnt_next = '1;
                    unique case (mode) inside
                        MODE_SDEC, MODE_UDEC:
                        begin
                            cell_ctrl.load = 1'b1;
                            mag_next       = neg ? MAG_W'(0) - low_word : low_word;
                            pfx_next       = neg ? PFX_MINUS : PFX_NONE;
                            state_next     = ST_CONV;
                        end
                        MODE_OCT, MODE_HEX:
                        begin
                            cell_ctrl.load = 1'b1;
                            pfx_next       = PFX_NONE;
                            state_next     = ST_SKIP;
                        end
                        MODE_HEX0X:
                        begin
                            cell_ctrl.load = 1'b1;
                            pfx_next       = PFX_ZERO;
                            state_next     = ST_SKIP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                cell_ctrl.dabble = 1'b1;
                mag_next         = {mag_reg[MAG_W-2:0], 1'b0};
                bit_cnt_next     = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == '0)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if (top_dig == '0 && rem_reg > REM_W'(1))
                begin
                    cell_ctrl.shift = 1'b1;
                    rem_next        = rem_reg - REM_W'(1);
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    case (pfx_reg)
                        PFX_MINUS:
                        begin
                            character_next = CHAR_MINUS;
                            last_next      = 1'b0;
                            pfx_next       = PFX_NONE;
                        end
                        PFX_ZERO:
                        begin
                            character_next = CHAR_0;
                            last_next      = 1'b0;
                            pfx_next       = PFX_X;
                        end
                        PFX_X:
                        begin
                            character_next = CHAR_X;
                            last_next      = 1'b0;
                            pfx_next       = PFX_NONE;
                        end
                        default:
                        begin
                            character_next  = digit_char(top_dig);
                            last_next       = (rem_reg == REM_W'(1));
                            cell_ctrl.shift = 1'b1;
                            rem_next        = rem_reg - REM_W'(1);
                            if (rem_reg == REM_W'(1))
                                state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
            pfx_reg       <= PFX_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            rem_reg       <= rem_next;
            pfx_reg       <= pfx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    // a prefix character never closes a text
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> character != CHAR_MINUS && character != CHAR_X)
        else $error("prefix character flagged as last");

    // double-dabble keeps every cell in BCD range
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> bcd_ok)
        else $error("digit cell left BCD range during conversion");

    // conversion leaves only after all magnitude bits went in
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SKIP && $past(state_reg) == ST_CONV |->
            $past(bit_cnt_reg) == '0)
        else $error("conversion ended early");

    // a word of a valid mode blocks further input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode <= MODE_HEX0X |=> !in_ready)
        else $error("input taken while a word is in work");

endmodule
